// File: rtl/banked_register_pool_allocator_assert.svh
// assertion macros used by the checker file
`ifndef BANKED_REGISTER_POOL_ALLOCATOR_ASSERT_SVH
`define BANKED_REGISTER_POOL_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BRPA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BRPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/brpa_pkg.sv
// ---------------------------------------------------------------------------
// brpa_pkg
// types, codes and defaults for the banked register pool allocator
// ---------------------------------------------------------------------------
package brpa_pkg;

    localparam int GLOBAL_COUNT_DEF = 64;
    localparam int FRAME_COUNT_DEF  = 128;
    localparam int TEMP_COUNT_DEF   = 48;
    localparam int MODULE_COUNT_DEF = 16;
    localparam int SCOPE_LEVELS_DEF = 6;
    localparam int REG_SPACE_DEF    = 256;
    localparam int GROUP_SLOTS      = 8;

    localparam logic [7:0] GLOBAL_BASE_RST = 8'd0;
    localparam logic [7:0] FRAME_BASE_RST  = 8'd64;
    localparam logic [7:0] TEMP_BASE_RST   = 8'd192;
    localparam logic [7:0] MODULE_BASE_RST = 8'd240;

    typedef enum logic [3:0] {
        KIND_ALLOC_GLOBAL = 4'd0,
        KIND_ALLOC_FRAME  = 4'd1,
        KIND_ALLOC_TEMP   = 4'd2,
        KIND_TEMP_RUN     = 4'd3,
        KIND_ALLOC_MODULE = 4'd4,
        KIND_ALLOC_SCOPED = 4'd5,
        KIND_FREE         = 4'd6,
        KIND_FREE_TEMP    = 4'd7,
        KIND_FREE_SCOPED  = 4'd8,
        KIND_RESERVE      = 4'd9,
        KIND_CLEAR_FRAME  = 4'd10,
        KIND_ENTER_SCOPE  = 4'd11,
        KIND_LEAVE_SCOPE  = 4'd12,
        KIND_SET_HINT     = 4'd13,
        KIND_QUERY        = 4'd14
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_NONE = 2'd1,
        ST_BAD  = 2'd2,
        ST_HINT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_IDX_GLOBAL = 2'd0,
        REG_IDX_FRAME  = 2'd1,
        REG_IDX_TEMP   = 2'd2,
        REG_IDX_MODULE = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        FSM_IDLE = 4'b0001,
        FSM_EXEC = 4'b0010,
        FSM_SCAN = 4'b0100,
        FSM_FIN  = 4'b1000
    } fsm_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic scan;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic in_scan;
        logic scan_done;
    } sts_t;

    // usable length of a region, cut at the end of the register space
    function automatic logic [8:0] region_len(input logic [7:0] base, input int count,
                                              input int space);
        int rest;
        rest = space - int'(base);
        if (rest <= 0)
            return 9'd0;
        else if (count > rest)
            return 9'(rest);
        else
            return 9'(count);
    endfunction

    function automatic logic in_region(input logic [7:0] r, input logic [7:0] base,
                                       input logic [8:0] len);
        return (r >= base) && (({1'b0, r} - {1'b0, base}) < len);
    endfunction

endpackage

// File: rtl/brpa_req_if.sv
// ---------------------------------------------------------------------------
// brpa_req_if
// request channel: valid/ready with the request fields
// ---------------------------------------------------------------------------
interface brpa_req_if;
    logic       valid;
    logic       ready;
    logic [3:0] kind;
    logic [7:0] reg_req;
    logic [5:0] run_length;
    logic [2:0] scope_index;
    logic       keep_flag;

    modport source (output valid, kind, reg_req, run_length, scope_index, keep_flag,
                    input ready);
    modport sink (input valid, kind, reg_req, run_length, scope_index, keep_flag,
                  output ready);
endinterface

// File: rtl/brpa_rsp_if.sv
// ---------------------------------------------------------------------------
// brpa_rsp_if
// result channel: valid/ready with the result fields
// ---------------------------------------------------------------------------
interface brpa_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] reg_out;
    logic [1:0] status;
    logic       is_free;

    modport source (output valid, reg_out, status, is_free, input ready);
    modport sink (input valid, reg_out, status, is_free, output ready);
endinterface

// File: rtl/banked_register_pool_allocator.sv
// ---------------------------------------------------------------------------
// banked_register_pool_allocator
// bitmap register allocator over four regions with scoped temp groups
// ---------------------------------------------------------------------------
// channel   dir  handshake     payload
// req       in   valid/ready   kind, reg_req, run_length, scope_index, keep_flag
// rsp       out  valid/ready   reg_out, status, is_free
// apb       in   psel/penable  paddr, pwdata, prdata (base registers)
//
// ops other than region allocates go through the execute state, then the finish state
// region allocates and temp runs scan one bitmap bit per cycle until a hit or the
// end of the region (the scan loop sets the rate)
// a result waits in its output register while the next item is taken
// reset clears all bitmaps, hints and the scope level at once
// ---------------------------------------------------------------------------
module banked_register_pool_allocator
#(
    parameter int GLOBAL_COUNT = brpa_pkg::GLOBAL_COUNT_DEF,
    parameter int FRAME_COUNT  = brpa_pkg::FRAME_COUNT_DEF,
    parameter int TEMP_COUNT   = brpa_pkg::TEMP_COUNT_DEF,
    parameter int MODULE_COUNT = brpa_pkg::MODULE_COUNT_DEF,
    parameter int SCOPE_LEVELS = brpa_pkg::SCOPE_LEVELS_DEF,
    parameter int REG_SPACE    = brpa_pkg::REG_SPACE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    brpa_req_if.sink    req,
    brpa_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    brpa_pkg::cmd_t cmd;
    brpa_pkg::sts_t sts;
    logic [7:0]     cfg_rdata;

    assign pready = 1'b1;
    assign prdata = {24'd0, cfg_rdata};

    brpa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    brpa_dp
    #(
        .GLOBAL_COUNT (GLOBAL_COUNT),
        .FRAME_COUNT  (FRAME_COUNT),
        .TEMP_COUNT   (TEMP_COUNT),
        .MODULE_COUNT (MODULE_COUNT),
        .SCOPE_LEVELS (SCOPE_LEVELS),
        .REG_SPACE    (REG_SPACE)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .kind        (req.kind),
        .reg_req     (req.reg_req),
        .run_length  (req.run_length),
        .scope_index (req.scope_index),
        .keep_flag   (req.keep_flag),
        .cfg_we      (psel && penable && pwrite),
        .cfg_idx     (paddr[3:2]),
        .cfg_wdata   (pwdata[7:0]),
        .cfg_rdata   (cfg_rdata),
        .reg_out     (rsp.reg_out),
        .status      (rsp.status),
        .is_free     (rsp.is_free)
    );

endmodule

// File: rtl/brpa_ctrl.sv
// ---------------------------------------------------------------------------
// brpa_ctrl
// sequencer: takes an item, runs one op or a bitmap scan, hands off the result
// ---------------------------------------------------------------------------
module brpa_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  brpa_pkg::sts_t    sts,
    output brpa_pkg::cmd_t    cmd
);

    brpa_pkg::fsm_t state_reg, state_next;
    logic           out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            brpa_pkg::FSM_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = sts.in_scan ? brpa_pkg::FSM_SCAN : brpa_pkg::FSM_EXEC;
                end
            end
            brpa_pkg::FSM_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = brpa_pkg::FSM_FIN;
            end
            brpa_pkg::FSM_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                    state_next = brpa_pkg::FSM_FIN;
            end
            brpa_pkg::FSM_FIN:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = brpa_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = brpa_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= brpa_pkg::FSM_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/brpa_dp.sv
// ---------------------------------------------------------------------------
// brpa_dp
// bitmaps, hints, scope state, base registers and the result registers
// ---------------------------------------------------------------------------
module brpa_dp
#(
    parameter int GLOBAL_COUNT = brpa_pkg::GLOBAL_COUNT_DEF,
    parameter int FRAME_COUNT  = brpa_pkg::FRAME_COUNT_DEF,
    parameter int TEMP_COUNT   = brpa_pkg::TEMP_COUNT_DEF,
    parameter int MODULE_COUNT = brpa_pkg::MODULE_COUNT_DEF,
    parameter int SCOPE_LEVELS = brpa_pkg::SCOPE_LEVELS_DEF,
    parameter int REG_SPACE    = brpa_pkg::REG_SPACE_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  brpa_pkg::cmd_t cmd,
    output brpa_pkg::sts_t sts,
    input  logic [3:0]     kind,
    input  logic [7:0]     reg_req,
    input  logic [5:0]     run_length,
    input  logic [2:0]     scope_index,
    input  logic           keep_flag,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_idx,
    input  logic [7:0]     cfg_wdata,
    output logic [7:0]     cfg_rdata,
    output logic [7:0]     reg_out,
    output logic [1:0]     status,
    output logic           is_free
);

    localparam int GIW = (GLOBAL_COUNT > 1) ? $clog2(GLOBAL_COUNT) : 1;
    localparam int FIW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int TIW = (TEMP_COUNT > 1) ? $clog2(TEMP_COUNT) : 1;
    localparam int MIW = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;
    localparam int LW  = (SCOPE_LEVELS > 1) ? $clog2(SCOPE_LEVELS) : 1;
    localparam int HW  = $clog2(REG_SPACE);

    // base registers
    logic [7:0] global_base_reg, frame_base_reg, temp_base_reg, module_base_reg;

    // allocator state
    logic [GLOBAL_COUNT-1:0] global_busy_reg, global_busy_next;
    logic [FRAME_COUNT-1:0]  frame_busy_reg, frame_busy_next;
    logic [TEMP_COUNT-1:0]   temp_busy_reg, temp_busy_next;
    logic [MODULE_COUNT-1:0] module_busy_reg, module_busy_next;
    logic [7:0]              scoped_busy_reg [SCOPE_LEVELS];
    logic [7:0]              scoped_busy_next [SCOPE_LEVELS];
    logic [2:0]              depth_reg, depth_next;
    logic [REG_SPACE-1:0]    hint_reg, hint_next;

    // latched request
    brpa_pkg::kind_t rq_kind_reg;
    logic [7:0]      rq_reg_reg;
    logic [5:0]      rq_run_reg;
    logic [2:0]      rq_lvl_reg;
    logic            rq_keep_reg;

    // scan state
    logic [8:0] idx_reg, idx_next;
    logic [8:0] start_reg, start_next;
    logic [5:0] cnt_reg, cnt_next;

    // pending and published results
    logic [7:0] res_reg_reg, res_reg_next;
    logic [1:0] res_st_reg, res_st_next;
    logic       res_free_reg, res_free_next;
    logic [7:0] out_reg_reg;
    logic [1:0] out_st_reg;
    logic       out_free_reg;

    logic [8:0] glen, flen, tlen, mlen;
    logic       in_g, in_f, in_t, in_m, hinted, lvl_ok;
    logic [7:0] off_g, off_f, off_t, off_m;
    logic [9:0] grp_base, grp_off;
    logic [7:0] lvl_mask;
    logic [7:0] r_base;
    logic [8:0] r_len;
    logic       bit_busy, scan_done, run_bad;
    logic [8:0] run_first;
    logic       sc_found, sc_stop;
    logic [2:0] sc_pick;

    assign glen = brpa_pkg::region_len(global_base_reg, GLOBAL_COUNT, REG_SPACE);
    assign flen = brpa_pkg::region_len(frame_base_reg, FRAME_COUNT, REG_SPACE);
    assign tlen = brpa_pkg::region_len(temp_base_reg, TEMP_COUNT, REG_SPACE);
    assign mlen = brpa_pkg::region_len(module_base_reg, MODULE_COUNT, REG_SPACE);

    assign in_g  = brpa_pkg::in_region(rq_reg_reg, global_base_reg, glen);
    assign in_f  = brpa_pkg::in_region(rq_reg_reg, frame_base_reg, flen);
    assign in_t  = brpa_pkg::in_region(rq_reg_reg, temp_base_reg, tlen);
    assign in_m  = brpa_pkg::in_region(rq_reg_reg, module_base_reg, mlen);
    assign off_g = rq_reg_reg - global_base_reg;
    assign off_f = rq_reg_reg - frame_base_reg;
    assign off_t = rq_reg_reg - temp_base_reg;
    assign off_m = rq_reg_reg - module_base_reg;

    assign hinted   = ({1'b0, rq_reg_reg} < 9'(REG_SPACE)) && hint_reg[rq_reg_reg[HW-1:0]];
    assign lvl_ok   = ({1'b0, rq_lvl_reg} < 4'(SCOPE_LEVELS));
    assign lvl_mask = scoped_busy_reg[rq_lvl_reg[LW-1:0]];
    assign grp_base = {2'b00, temp_base_reg} + {4'b0000, rq_lvl_reg, 3'b000};
    assign grp_off  = {2'b00, rq_reg_reg} - grp_base;

    // region under scan
    always_comb
    begin
        unique case (rq_kind_reg)
            brpa_pkg::KIND_ALLOC_GLOBAL:
            begin
                r_base   = global_base_reg;
                r_len    = glen;
                bit_busy = global_busy_reg[idx_reg[GIW-1:0]];
            end
            brpa_pkg::KIND_ALLOC_FRAME:
            begin
                r_base   = frame_base_reg;
                r_len    = flen;
                bit_busy = frame_busy_reg[idx_reg[FIW-1:0]];
            end
            brpa_pkg::KIND_ALLOC_MODULE:
            begin
                r_base   = module_base_reg;
                r_len    = mlen;
                bit_busy = module_busy_reg[idx_reg[MIW-1:0]];
            end
            default:
            begin
                r_base   = temp_base_reg;
                r_len    = tlen;
                bit_busy = temp_busy_reg[idx_reg[TIW-1:0]];
            end
        endcase
    end

    assign run_bad   = (rq_kind_reg == brpa_pkg::KIND_TEMP_RUN) &&
                       ((rq_run_reg == 6'd0) || ({3'b000, rq_run_reg} > 9'(TEMP_COUNT)));
    assign run_first = (cnt_reg == 6'd0) ? idx_reg : start_reg;

    // scoped slot search, at most eight slots
    always_comb
    begin
        sc_found = 1'b0;
        sc_stop  = 1'b0;
        sc_pick  = 3'd0;
        for (int i = 0; i < brpa_pkg::GROUP_SLOTS; i++)
        begin
            if (!sc_found && !sc_stop)
            begin
                if ((grp_base + 10'(i)) >= 10'(REG_SPACE))
                    sc_stop = 1'b1;
                else if (!lvl_mask[i])
                begin
                    sc_found = 1'b1;
                    sc_pick  = 3'(i);
                end
            end
        end
    end

    always_comb
    begin
        global_busy_next = global_busy_reg;
        frame_busy_next  = frame_busy_reg;
        temp_busy_next   = temp_busy_reg;
        module_busy_next = module_busy_reg;
        scoped_busy_next = scoped_busy_reg;
        depth_next       = depth_reg;
        hint_next        = hint_reg;
        idx_next         = idx_reg;
        start_next       = start_reg;
        cnt_next         = cnt_reg;
        res_reg_next     = res_reg_reg;
        res_st_next      = res_st_reg;
        res_free_next    = res_free_reg;
        scan_done        = 1'b0;

        if (cmd.latch)
        begin
            idx_next   = '0;
            start_next = '0;
            cnt_next   = '0;
        end

        if (cmd.exec)
        begin
            res_reg_next  = 8'd0;
            res_st_next   = brpa_pkg::ST_BAD;
            res_free_next = 1'b0;
            unique case (rq_kind_reg)
                brpa_pkg::KIND_ALLOC_SCOPED:
                begin
                    if (lvl_ok)
                    begin
                        if (sc_found)
                        begin
                            scoped_busy_next[rq_lvl_reg[LW-1:0]][sc_pick] = 1'b1;
                            res_reg_next = grp_base[7:0] + {5'b00000, sc_pick};
                            res_st_next  = brpa_pkg::ST_DONE;
                        end
                        else
                            res_st_next = brpa_pkg::ST_NONE;
                    end
                end
                brpa_pkg::KIND_FREE:
                begin
                    priority if (hinted)
                        res_st_next = brpa_pkg::ST_HINT;
                    else if (in_g)
                    begin
                        global_busy_next[off_g[GIW-1:0]] = 1'b0;
                        res_st_next = brpa_pkg::ST_DONE;
                    end
                    else if (in_f)
                    begin
                        frame_busy_next[off_f[FIW-1:0]] = 1'b0;
                        res_st_next = brpa_pkg::ST_DONE;
                    end
                    else if (in_t)
                    begin
                        temp_busy_next[off_t[TIW-1:0]] = 1'b0;
                        res_st_next = brpa_pkg::ST_DONE;
                    end
                    else if (in_m)
                    begin
                        module_busy_next[off_m[MIW-1:0]] = 1'b0;
                        res_st_next = brpa_pkg::ST_DONE;
                    end
                    else
                        res_st_next = brpa_pkg::ST_BAD;
                end
                brpa_pkg::KIND_FREE_TEMP:
                begin
                    if (in_t)
                    begin
                        if (hinted)
                            res_st_next = brpa_pkg::ST_HINT;
                        else
                        begin
                            temp_busy_next[off_t[TIW-1:0]] = 1'b0;
                            res_st_next = brpa_pkg::ST_DONE;
                        end
                    end
                end
                brpa_pkg::KIND_FREE_SCOPED:
                begin
                    if (lvl_ok && ({2'b00, rq_reg_reg} >= grp_base) &&
                        (grp_off < 10'(brpa_pkg::GROUP_SLOTS)))
                    begin
                        scoped_busy_next[rq_lvl_reg[LW-1:0]][grp_off[2:0]] = 1'b0;
                        res_st_next = brpa_pkg::ST_DONE;
                    end
                end
                brpa_pkg::KIND_RESERVE:
                begin
                    if (in_g)
                    begin
                        global_busy_next[off_g[GIW-1:0]] = 1'b1;
                        res_st_next = brpa_pkg::ST_DONE;
                    end
                end
                brpa_pkg::KIND_CLEAR_FRAME:
                begin
                    frame_busy_next = '0;
                    res_st_next     = brpa_pkg::ST_DONE;
                end
                brpa_pkg::KIND_ENTER_SCOPE:
                begin
                    if (({1'b0, depth_reg} + 4'd1) < 4'(SCOPE_LEVELS))
                    begin
                        depth_next  = depth_reg + 3'd1;
                        res_st_next = brpa_pkg::ST_DONE;
                    end
                end
                brpa_pkg::KIND_LEAVE_SCOPE:
                begin
                    if ((depth_reg != 3'd0) && ({1'b0, depth_reg} < 4'(SCOPE_LEVELS)))
                    begin
                        scoped_busy_next[depth_reg[LW-1:0]] = 8'd0;
                        depth_next  = depth_reg - 3'd1;
                        res_st_next = brpa_pkg::ST_DONE;
                    end
                end
                brpa_pkg::KIND_SET_HINT:
                begin
                    if ({1'b0, rq_reg_reg} < 9'(REG_SPACE))
                    begin
                        hint_next[rq_reg_reg[HW-1:0]] = rq_keep_reg;
                        res_st_next = brpa_pkg::ST_DONE;
                    end
                end
                brpa_pkg::KIND_QUERY:
                begin
                    res_st_next = brpa_pkg::ST_DONE;
                    priority if (in_g)
                        res_free_next = !global_busy_reg[off_g[GIW-1:0]];
                    else if (in_f)
                        res_free_next = !frame_busy_reg[off_f[FIW-1:0]];
                    else if (in_t)
                        res_free_next = !temp_busy_reg[off_t[TIW-1:0]];
                    else if (in_m)
                        res_free_next = !module_busy_reg[off_m[MIW-1:0]];
                    else
                        res_st_next = brpa_pkg::ST_BAD;
                end
                default:
                begin
                    res_st_next = brpa_pkg::ST_BAD;
                end
            endcase
        end

        // one bitmap position per cycle
        if (cmd.scan)
        begin
            res_reg_next  = 8'd0;
            res_free_next = 1'b0;
            priority if (run_bad)
            begin
                scan_done   = 1'b1;
                res_st_next = brpa_pkg::ST_BAD;
            end
            else if (idx_reg >= r_len)
            begin
                scan_done   = 1'b1;
                res_st_next = brpa_pkg::ST_NONE;
            end
            else if (rq_kind_reg == brpa_pkg::KIND_TEMP_RUN)
            begin
                idx_next = idx_reg + 9'd1;
                if (bit_busy)
                    cnt_next = 6'd0;
                else if ((cnt_reg + 6'd1) == rq_run_reg)
                begin
                    for (int j = 0; j < TEMP_COUNT; j++)
                    begin
                        if ((9'(j) >= run_first) && (9'(j) <= idx_reg))
                            temp_busy_next[j] = 1'b1;
                    end
                    scan_done    = 1'b1;
                    res_reg_next = r_base + run_first[7:0];
                    res_st_next  = brpa_pkg::ST_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 6'd1;
                    start_next = run_first;
                end
            end
            else if (!bit_busy)
            begin
                unique case (rq_kind_reg)
                    brpa_pkg::KIND_ALLOC_GLOBAL:
                        global_busy_next[idx_reg[GIW-1:0]] = 1'b1;
                    brpa_pkg::KIND_ALLOC_FRAME:
                        frame_busy_next[idx_reg[FIW-1:0]] = 1'b1;
                    brpa_pkg::KIND_ALLOC_MODULE:
                        module_busy_next[idx_reg[MIW-1:0]] = 1'b1;
                    default:
                        temp_busy_next[idx_reg[TIW-1:0]] = 1'b1;
                endcase
                scan_done    = 1'b1;
                res_reg_next = r_base + idx_reg[7:0];
                res_st_next  = brpa_pkg::ST_DONE;
            end
            else
                idx_next = idx_reg + 9'd1;
        end
    end

    always_comb
    begin
        unique case (brpa_pkg::kind_t'(kind))
            brpa_pkg::KIND_ALLOC_GLOBAL, brpa_pkg::KIND_ALLOC_FRAME,
            brpa_pkg::KIND_ALLOC_TEMP, brpa_pkg::KIND_TEMP_RUN,
            brpa_pkg::KIND_ALLOC_MODULE:
                sts.in_scan = 1'b1;
            default:
                sts.in_scan = 1'b0;
        endcase
    end
    assign sts.scan_done = scan_done;

    always_comb
    begin
        unique case (brpa_pkg::cfg_idx_t'(cfg_idx))
            brpa_pkg::REG_IDX_GLOBAL: cfg_rdata = global_base_reg;
            brpa_pkg::REG_IDX_FRAME:  cfg_rdata = frame_base_reg;
            brpa_pkg::REG_IDX_TEMP:   cfg_rdata = temp_base_reg;
            default:                  cfg_rdata = module_base_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            global_base_reg <= brpa_pkg::GLOBAL_BASE_RST;
            frame_base_reg  <= brpa_pkg::FRAME_BASE_RST;
            temp_base_reg   <= brpa_pkg::TEMP_BASE_RST;
            module_base_reg <= brpa_pkg::MODULE_BASE_RST;
            global_busy_reg <= '0;
            frame_busy_reg  <= '0;
            temp_busy_reg   <= '0;
            module_busy_reg <= '0;
            for (int s = 0; s < SCOPE_LEVELS; s++)
                scoped_busy_reg[s] <= 8'd0;
            depth_reg <= 3'd0;
            hint_reg  <= '0;
            idx_reg   <= '0;
            start_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (brpa_pkg::cfg_idx_t'(cfg_idx))
                    brpa_pkg::REG_IDX_GLOBAL: global_base_reg <= cfg_wdata;
                    brpa_pkg::REG_IDX_FRAME:  frame_base_reg  <= cfg_wdata;
                    brpa_pkg::REG_IDX_TEMP:   temp_base_reg   <= cfg_wdata;
                    default:                  module_base_reg <= cfg_wdata;
                endcase
            end
            global_busy_reg <= global_busy_next;
            frame_busy_reg  <= frame_busy_next;
            temp_busy_reg   <= temp_busy_next;
            module_busy_reg <= module_busy_next;
            scoped_busy_reg <= scoped_busy_next;
            depth_reg       <= depth_next;
            hint_reg        <= hint_next;
            idx_reg         <= idx_next;
            start_reg       <= start_next;
            cnt_reg         <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            rq_kind_reg <= brpa_pkg::kind_t'(kind);
            rq_reg_reg  <= reg_req;
            rq_run_reg  <= run_length;
            rq_lvl_reg  <= scope_index;
            rq_keep_reg <= keep_flag;
        end
        res_reg_reg  <= res_reg_next;
        res_st_reg   <= res_st_next;
        res_free_reg <= res_free_next;
        if (cmd.publish)
        begin
            out_reg_reg  <= res_reg_reg;
            out_st_reg   <= res_st_reg;
            out_free_reg <= res_free_reg;
        end
    end

    assign reg_out = out_reg_reg;
    assign status  = out_st_reg;
    assign is_free = out_free_reg;

endmodule

// File: rtl/brpa_checker.sv
// ---------------------------------------------------------------------------
// brpa_checker
// port-level checks on the allocator, bound to the top level
// ---------------------------------------------------------------------------
`include "banked_register_pool_allocator_assert.svh"

module brpa_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] reg_out,
    input logic [1:0] status,
    input logic       is_free
);

    logic stalled;
    logic failed;
    assign stalled = out_valid && !out_ready;
    assign failed  = out_valid && (status != brpa_pkg::ST_DONE);

    // a stalled result keeps its fields
    `BRPA_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(reg_out) && $stable(status) && $stable(is_free))
    // nothing allocated on failure
    `BRPA_ASSERT_NOW(a_fail_zero, failed, (reg_out == 8'd0) && !is_free)
    // an accepted item occupies the block for at least the next cycle
    `BRPA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

bind banked_register_pool_allocator brpa_checker u_brpa_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .reg_out   (rsp.reg_out),
    .status    (rsp.status),
    .is_free   (rsp.is_free)
);
